// ===== rtl/ibms_pkg.sv =====
// Shared types and constants for the interleaved block media store.
// Holds function, status and media codes, the sector interleave table and the
// control struct passed from the address mapper to the top level.
package ibms_pkg;

	localparam int FUNC_W   = 2;
	localparam int BLOCK_W  = 10;
	localparam int OFFSET_W = 10;
	localparam int BYTE_W   = 8;
	localparam int STATUS_W = 2;
	localparam int MEDIA_W  = 2;
	localparam int CFG_ADDR_W = 1;
	localparam int CFG_DATA_W = 2;

	// Sectors are remapped inside groups of eight.
	localparam int GROUP_BITS = 3;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_READ  = 2'd0,
		FUNC_WRITE = 2'd1,
		FUNC_LOAD  = 2'd2,
		FUNC_CLEAR = 2'd3
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_NO_MEDIA  = 2'd1,
		ST_PROTECTED = 2'd2,
		ST_RANGE     = 2'd3
	} status_t;

	typedef enum logic [MEDIA_W-1:0] {
		MEDIA_NONE       = 2'd0,
		MEDIA_DATA_PACK  = 2'd1,
		MEDIA_DISK_SMALL = 2'd2,
		MEDIA_DISK_LARGE = 2'd3
	} media_t;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_MEDIA_KIND    = 1'd0,
		REG_WRITE_PROTECT = 1'd1
	} cfg_reg_t;

	// Outcome of one item as decided by the address mapper.
	typedef struct packed {
		status_t status;
		logic    rd;
		logic    wr;
		logic    set_pos;
		logic    set_dirty;
		logic    clr_dirty;
	} map_ctl_t;

	function automatic logic [GROUP_BITS-1:0] interleave(input logic [GROUP_BITS-1:0] s);
		logic [GROUP_BITS-1:0] p;
		case (s)
			3'd0:    p = 3'd0;
			3'd1:    p = 3'd5;
			3'd2:    p = 3'd2;
			3'd3:    p = 3'd7;
			3'd4:    p = 3'd4;
			3'd5:    p = 3'd1;
			3'd6:    p = 3'd6;
			default: p = 3'd3;
		endcase
		return p;
	endfunction

endpackage

// ===== rtl/ibms_ifaces.sv =====
// Handshake channels of the interleaved block media store: request, response
// and configuration write. Field widths come from ibms_pkg.
interface ibms_req_if
	import ibms_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [FUNC_W-1:0]   func;
	logic [BLOCK_W-1:0]  block_number;
	logic [OFFSET_W-1:0] byte_offset;
	logic [BYTE_W-1:0]   write_byte;

	modport source(output valid, func, block_number, byte_offset, write_byte, input ready);
	modport sink(input valid, func, block_number, byte_offset, write_byte, output ready);
endinterface

interface ibms_rsp_if
	import ibms_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [BYTE_W-1:0]   read_byte;
	logic [STATUS_W-1:0] status;
	logic [BLOCK_W-1:0]  last_block;
	logic                dirty;

	modport source(output valid, read_byte, status, last_block, dirty, input ready);
	modport sink(input valid, read_byte, status, last_block, dirty, output ready);
endinterface

interface ibms_cfg_if
	import ibms_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic [CFG_ADDR_W-1:0] addr;
	logic [CFG_DATA_W-1:0] data;

	modport source(output valid, addr, data, input ready);
	modport sink(input valid, addr, data, output ready);
endinterface

// ===== rtl/ibms_addr_map.sv =====
// Address mapper: checks one item against media, protection and image size
// and maps block and offset to an image address (linear or interleaved).
// Depends on ibms_pkg.
module ibms_addr_map
	import ibms_pkg::*;
#(
	parameter int BLOCK_BYTES       = 1024,
	parameter int SECTOR_BYTES      = 512,
	parameter int STORE_BYTES       = 524288,
	parameter int DATA_PACK_BLOCKS  = 256,
	parameter int DISK_SMALL_BLOCKS = 160,
	parameter int DISK_LARGE_BLOCKS = 320,
	parameter int AW                = $clog2(STORE_BYTES)
) (
	input  logic [MEDIA_W-1:0]  media_kind,
	input  logic                write_protect,
	input  logic [FUNC_W-1:0]   func,
	input  logic [BLOCK_W-1:0]  block_number,
	input  logic [OFFSET_W-1:0] byte_offset,
	output map_ctl_t            ctl,
	output logic [AW-1:0]       addr
);

	localparam int SPB     = BLOCK_BYTES / SECTOR_BYTES;
	localparam int NBLK    = 1 << BLOCK_W;
	localparam int SEC_W   = $clog2(NBLK * SPB + 16);
	localparam int DSK_W   = $clog2((1 << SEC_W) * SECTOR_BYTES);
	localparam int LIN_W   = $clog2(NBLK * BLOCK_BYTES + (1 << OFFSET_W));
	localparam int STO_W   = $clog2(STORE_BYTES + 1);
	localparam int MW0     = (DSK_W > LIN_W) ? DSK_W : LIN_W;
	localparam int MAP_W   = (MW0 > STO_W) ? MW0 : STO_W;
	localparam int CMP_W   = $clog2(8 * SECTOR_BYTES + (1 << OFFSET_W));
	localparam int Q_W     = OFFSET_W - $clog2(128) + 1;
	localparam int QMAX    = (1 << OFFSET_W) / SECTOR_BYTES;
	localparam int DP_SZ   = DATA_PACK_BLOCKS * BLOCK_BYTES;
	localparam int DS_SZ   = DISK_SMALL_BLOCKS * BLOCK_BYTES;
	localparam int DL_SZ   = DISK_LARGE_BLOCKS * BLOCK_BYTES;
	localparam int DP_LIM  = (DP_SZ < STORE_BYTES) ? DP_SZ : STORE_BYTES;
	localparam int DS_LIM  = (DS_SZ < STORE_BYTES) ? DS_SZ : STORE_BYTES;
	localparam int DL_LIM  = (DL_SZ < STORE_BYTES) ? DL_SZ : STORE_BYTES;

	logic [Q_W-1:0]      sec_q;
	logic [OFFSET_W-1:0] sec_rem;
	logic [SEC_W-1:0]    sector;
	logic [SEC_W-1:0]    phys;
	logic [MAP_W-1:0]    lin_addr;
	logic [MAP_W-1:0]    dsk_addr;
	logic [MAP_W-1:0]    blk_addr;
	logic [MAP_W-1:0]    limit;
	logic [BLOCK_W:0]    kind_blocks;
	logic                ofs_ok;
	logic                blk_ok;

	// Sector within the block: offset is at most ten bits, so a handful of
	// compares against sector boundaries replaces the division.
	always_comb begin
		sec_q = '0;
		for (int k = 1; k <= QMAX && k < 16; k++) begin
			if (CMP_W'(byte_offset) >= CMP_W'(k * SECTOR_BYTES)) begin
				sec_q = Q_W'(k);
			end
		end
	end

	assign sec_rem  = OFFSET_W'(CMP_W'(byte_offset) - CMP_W'(sec_q) * CMP_W'(SECTOR_BYTES));
	assign sector   = SEC_W'(block_number) * SEC_W'(SPB) + SEC_W'(sec_q);
	assign phys     = {sector[SEC_W-1:GROUP_BITS], interleave(sector[GROUP_BITS-1:0])};
	assign dsk_addr = MAP_W'(phys) * MAP_W'(SECTOR_BYTES) + MAP_W'(sec_rem);
	assign lin_addr = MAP_W'(block_number) * MAP_W'(BLOCK_BYTES) + MAP_W'(byte_offset);
	assign blk_addr = (media_t'(media_kind) == MEDIA_DATA_PACK) ? lin_addr : dsk_addr;
	assign ofs_ok   = (CMP_W'(byte_offset) < CMP_W'(BLOCK_BYTES));
	assign blk_ok   = ({1'b0, block_number} < kind_blocks);

	always_comb begin
		unique case (media_t'(media_kind))
			MEDIA_DATA_PACK: begin
				kind_blocks = (BLOCK_W+1)'(DATA_PACK_BLOCKS);
				limit       = MAP_W'(DP_LIM);
			end
			MEDIA_DISK_SMALL: begin
				kind_blocks = (BLOCK_W+1)'(DISK_SMALL_BLOCKS);
				limit       = MAP_W'(DS_LIM);
			end
			MEDIA_DISK_LARGE: begin
				kind_blocks = (BLOCK_W+1)'(DISK_LARGE_BLOCKS);
				limit       = MAP_W'(DL_LIM);
			end
			default: begin
				kind_blocks = '0;
				limit       = '0;
			end
		endcase
	end

	always_comb begin
		ctl  = '{status: ST_OK, default: 1'b0};
		addr = blk_addr[AW-1:0];
		unique case (func_t'(func))
			FUNC_CLEAR: begin
				ctl.clr_dirty = 1'b1;
			end
			FUNC_LOAD: begin
				addr = lin_addr[AW-1:0];
				if (ofs_ok && lin_addr < MAP_W'(STORE_BYTES)) begin
					ctl.wr = 1'b1;
				end else begin
					ctl.status = ST_RANGE;
				end
			end
			default: begin
				if (media_t'(media_kind) == MEDIA_NONE) begin
					ctl.status = ST_NO_MEDIA;
				end else if (func_t'(func) == FUNC_WRITE && write_protect) begin
					ctl.status = ST_PROTECTED;
				end else if (!blk_ok || !ofs_ok || blk_addr >= limit) begin
					ctl.status = ST_RANGE;
				end else begin
					ctl.set_pos   = 1'b1;
					ctl.rd        = (func_t'(func) == FUNC_READ);
					ctl.wr        = (func_t'(func) == FUNC_WRITE);
					ctl.set_dirty = (func_t'(func) == FUNC_WRITE);
				end
			end
		endcase
	end

endmodule

// ===== rtl/ibms_image_ram.sv =====
// Byte-wide single-port image memory with registered read data.
// No reset; contents are undefined until written. Depends on nothing else.
module ibms_image_ram #(
	parameter int DEPTH = 524288,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic          re,
	input  logic [AW-1:0] addr,
	input  logic [7:0]    wdata,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

// ===== rtl/interleaved_block_media_store.sv =====
// Top level of the interleaved block media store: config registers, request
// decode, image memory access and response stage. Depends on ibms_pkg,
// ibms_ifaces, ibms_addr_map and ibms_image_ram.
//
//   port  | dir | carries
//   ------+-----+-----------------------------------------------------
//   cfg   | in  | register write: addr (0 media_kind, 1 write_protect), data
//   req   | in  | item: func, block_number, byte_offset, write_byte
//   rsp   | out | result: read_byte, status, last_block, dirty
//
// One item per cycle sustained while rsp is ready; a result is offered once
// its item has been registered into stage one by decode and the memory
// access has filled stage two through the registered read port.
// Items touch the memory in order through its single port, so a read always
// sees every earlier write.
// rsp stalls back up through both stages into req.ready; cfg is always ready.
// Reset clears the config registers, last block, dirty mark and valid bits;
// the image memory is not cleared.
module interleaved_block_media_store
	import ibms_pkg::*;
#(
	parameter int BLOCK_BYTES       = 1024,
	parameter int SECTOR_BYTES      = 512,
	parameter int STORE_BYTES       = 524288,
	parameter int DATA_PACK_BLOCKS  = 256,
	parameter int DISK_SMALL_BLOCKS = 160,
	parameter int DISK_LARGE_BLOCKS = 320
) (
	input  logic      clk,
	input  logic      arst_n,
	ibms_cfg_if.sink  cfg,
	ibms_req_if.sink  req,
	ibms_rsp_if.source rsp
);

	localparam int AW = $clog2(STORE_BYTES);

	logic [MEDIA_W-1:0] media_kind_q;
	logic               write_protect_q;
	logic [BLOCK_W-1:0] pos_q;
	logic               dirty_q;
	logic [BLOCK_W-1:0] pos_nxt;
	logic               dirty_nxt;

	map_ctl_t           ctl;
	logic [AW-1:0]      addr;

	logic               valid_s1;
	map_ctl_t           ctl_s1;
	logic [AW-1:0]      addr_s1;
	logic [BYTE_W-1:0]  wdata_s1;
	logic [BLOCK_W-1:0] pos_s1;
	logic               dirty_s1;

	logic               valid_s2;
	logic               rd_s2;
	status_t            status_s2;
	logic [BLOCK_W-1:0] pos_s2;
	logic               dirty_s2;
	logic [BYTE_W-1:0]  ram_rdata;

	logic               adv_s2;
	logic               adv_s1;
	logic               in_acc;
	logic               mem_go;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			media_kind_q    <= MEDIA_NONE;
			write_protect_q <= 1'b0;
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.addr))
				REG_MEDIA_KIND:    media_kind_q    <= cfg.data;
				REG_WRITE_PROTECT: write_protect_q <= cfg.data[0];
				default: ;
			endcase
		end
	end

	ibms_addr_map #(
		.BLOCK_BYTES      (BLOCK_BYTES),
		.SECTOR_BYTES     (SECTOR_BYTES),
		.STORE_BYTES      (STORE_BYTES),
		.DATA_PACK_BLOCKS (DATA_PACK_BLOCKS),
		.DISK_SMALL_BLOCKS(DISK_SMALL_BLOCKS),
		.DISK_LARGE_BLOCKS(DISK_LARGE_BLOCKS),
		.AW               (AW)
	) u_map (
		.media_kind   (media_kind_q),
		.write_protect(write_protect_q),
		.func         (req.func),
		.block_number (req.block_number),
		.byte_offset  (req.byte_offset),
		.ctl          (ctl),
		.addr         (addr)
	);

	assign adv_s2    = !valid_s2 || rsp.ready;
	assign adv_s1    = !valid_s1 || adv_s2;
	assign req.ready = adv_s1;
	assign in_acc    = req.valid && adv_s1;
	assign mem_go    = valid_s1 && adv_s2;

	assign pos_nxt   = ctl.set_pos ? req.block_number : pos_q;
	assign dirty_nxt = ctl.set_dirty ? 1'b1 : (ctl.clr_dirty ? 1'b0 : dirty_q);

	// Last block and dirty mark advance in item order at acceptance.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			dirty_q <= 1'b0;
		end else if (in_acc) begin
			pos_q   <= pos_nxt;
			dirty_q <= dirty_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= req.valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			ctl_s1   <= ctl;
			addr_s1  <= addr;
			wdata_s1 <= req.write_byte;
			pos_s1   <= pos_nxt;
			dirty_s1 <= dirty_nxt;
		end
		if (mem_go) begin
			rd_s2     <= ctl_s1.rd;
			status_s2 <= ctl_s1.status;
			pos_s2    <= pos_s1;
			dirty_s2  <= dirty_s1;
		end
	end

	ibms_image_ram #(
		.DEPTH(STORE_BYTES),
		.AW   (AW)
	) u_ram (
		.clk  (clk),
		.we   (mem_go && ctl_s1.wr),
		.re   (mem_go && ctl_s1.rd),
		.addr (addr_s1),
		.wdata(wdata_s1),
		.rdata(ram_rdata)
	);

	assign rsp.valid      = valid_s2;
	assign rsp.read_byte  = rd_s2 ? ram_rdata : '0;
	assign rsp.status     = status_s2;
	assign rsp.last_block = pos_s2;
	assign rsp.dirty      = dirty_s2;

endmodule

// ===== rtl/ibms_checker.sv =====
// Port-level checks for the interleaved block media store, bound to the top
// level. Depends on ibms_pkg.
module ibms_checker
	import ibms_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input logic [BYTE_W-1:0]   rsp_read_byte,
	input logic [STATUS_W-1:0] rsp_status,
	input logic [BLOCK_W-1:0]  rsp_last_block,
	input logic                rsp_dirty
);

	logic               out_acc;
	logic [BLOCK_W-1:0] last_q;
	logic               dirty_q;

	assign out_acc = rsp_valid && rsp_ready;

	// Hold what the previous delivered result showed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q  <= '0;
			dirty_q <= 1'b0;
		end else if (out_acc) begin
			last_q  <= rsp_last_block;
			dirty_q <= rsp_dirty;
		end
	end

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != ST_OK |-> rsp_read_byte == '0)
		else $error("failed item returned nonzero data");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_read_byte))
		else $error("stalled result changed");

	a_dirty_rise: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && rsp_dirty && !dirty_q |-> rsp_status == ST_OK)
		else $error("dirty set by a failed item");

	a_pos_move: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && rsp_last_block != last_q |-> rsp_status == ST_OK)
		else $error("last block moved on a failed item");

endmodule

bind interleaved_block_media_store ibms_checker u_ibms_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_read_byte (rsp.read_byte),
	.rsp_status    (rsp.status),
	.rsp_last_block(rsp.last_block),
	.rsp_dirty     (rsp.dirty)
);
